>>> src/hysteresis_fan_pump_controller_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fan and pump controller
// Clocked on clk, switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_FAN_PUMP_CONTROLLER_UNIT_MACROS_SVH
`define HYSTERESIS_FAN_PUMP_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define HFPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HFPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hfpc_pkg.sv
// ---------------------------------------------------------------------------
// hfpc_pkg
// Types, constants and helpers for the fan and pump controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfpc_pkg;

    localparam int IN_W   = 96;
    localparam int OUT_W  = 24;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 32;

    // shared divider
    localparam int DVD_W = 19;
    localparam int DVS_W = 12;
    localparam int CNT_W = 5;

    // temperature, 0.1 C, at which the fan reaches full duty
    localparam logic signed [11:0] FAN_FULL_TEMP = 12'sd600;
    localparam logic [6:0]         DUTY_MAX      = 7'd100;

    typedef enum logic [CIDX_W-1:0] {
        REG_SENSOR_PERIOD  = 3'd0,
        REG_CONTROL_PERIOD = 3'd1,
        REG_SETTING_TMO    = 3'd2,
        REG_TEMP_SET       = 3'd3,
        REG_TEMP_RST       = 3'd4,
        REG_HUM_SET        = 3'd5,
        REG_HUM_RST        = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FAN_DIV,
        ST_FAN_WB,
        ST_PUMP_DIV,
        ST_PUMP_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic eval_en;
        logic div_step;
        logic fan_wb;
        logic pump_wb;
        logic out_load;
    } ctl_t;

    // x * 100 by shift and add
    function automatic logic [DVD_W-1:0] mul100(input logic [11:0] x);
        logic [DVD_W-1:0] xe;
        xe = {{(DVD_W-12){1'b0}}, x};
        return (xe << 6) + (xe << 5) + (xe << 2);
    endfunction

endpackage

>>> src/hysteresis_fan_pump_controller_unit.sv
// ---------------------------------------------------------------------------
// hysteresis_fan_pump_controller_unit
// Poll-driven fan and pump hysteresis controller with proportional duty.
// ---------------------------------------------------------------------------
// Input beats on s_axis carry one poll; each poll gives exactly one output
// beat on m_axis with mode, enables, duties and event pulses.
// Settings are written through cfg_we / cfg_index / cfg_data, one register
// per cycle; the user must write them only while no poll is in flight, as
// the block itself does not enforce it. A poll that needs no duty quotient
// goes from acceptance through the evaluate state to the done state; a fan
// or pump duty quotient each adds 19 steps of the shared restoring divider
// and a write-back state. The divider is shared; fan and pump quotients go
// through it one after the other. One poll is in flight at a time:
// s_axis_tready is high only in idle, so a new poll waits for the last one.
// The result sits in an output register; a stalled receiver holds it while
// the next poll is accepted and worked on, and that poll waits in its final
// state until the register is free.
// Reset clears the mode, timestamps, enables and duties, loads the settings
// with their defaults and leaves the block idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hysteresis_fan_pump_controller_unit_macros.svh"

module hysteresis_fan_pump_controller_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hfpc_pkg::CIDX_W-1:0] cfg_index,
    input  logic [hfpc_pkg::CDAT_W-1:0] cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // now_ms[31:0], temperature[43:32], temp_present[44], soil_humidity[54:45],
    // hum_present[55], last_ui_action_ms[87:56], enter_setting[88], zero pad
    input  logic [hfpc_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // mode[0], fan_on[1], fan_duty[8:2], pump_on[9], pump_duty[16:10],
    // sensor_update[17], force_all_on[18], menu_to_main[19], zero pad
    output logic [hfpc_pkg::OUT_W-1:0]  m_axis_tdata
);

    import hfpc_pkg::*;

    // settings
    logic [15:0]        sensor_period_reg;
    logic [15:0]        control_period_reg;
    logic [31:0]        setting_tmo_reg;
    logic signed [11:0] temp_set_reg;
    logic signed [10:0] temp_rst_reg;
    logic [9:0]         hum_set_reg;
    logic [9:0]         hum_rst_reg;

    // controller state
    state_t      state_reg, state_next;
    ctl_t        ctl;
    logic        mode_reg;
    logic [31:0] last_sensor_reg;
    logic [31:0] last_control_reg;
    logic        fan_on_reg;
    logic [6:0]  fan_duty_reg;
    logic        pump_on_reg;
    logic [6:0]  pump_duty_reg;
    logic        sensor_pulse_reg;
    logic        forced_reg;
    logic        to_main_reg;
    logic        pump_pend_reg;

    // captured poll
    logic [31:0]        now_reg;
    logic signed [11:0] temp_reg;
    logic               temp_present_reg;
    logic [9:0]         hum_reg;
    logic               hum_present_reg;
    logic [31:0]        ui_reg;
    logic               enter_reg;

    // divider
    logic [DVD_W-1:0] dvd_q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W+1:0] trial;
    logic             fits;
    logic             div_last;
    logic             div_load;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // evaluation terms
    logic               mode_eff;
    logic               sensor_due;
    logic               control_due;
    logic               tmo_hit;
    logic signed [11:0] temp_rst_ext;
    logic               fan_off;
    logic               fan_prop;
    logic signed [12:0] fan_span;
    logic               span_pos;
    logic signed [12:0] fan_diff;
    logic               pump_off;
    logic               pump_prop;
    logic [9:0]         pump_diff;
    logic [DVD_W-1:0]   fan_num;
    logic [DVD_W-1:0]   pump_num;
    logic               fan_div_go;
    logic               pump_div_go;
    logic               out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ---- evaluation ----
    assign mode_eff     = mode_reg | enter_reg;
    assign sensor_due   = (now_reg - last_sensor_reg) >= {16'd0, sensor_period_reg};
    assign control_due  = (now_reg - last_control_reg) >= {16'd0, control_period_reg};
    assign tmo_hit      = (now_reg - ui_reg) >= setting_tmo_reg;

    assign temp_rst_ext = {temp_rst_reg[10], temp_rst_reg};
    assign fan_off      = temp_present_reg && (temp_reg < temp_rst_ext);
    assign fan_prop     = temp_present_reg && !(temp_reg < temp_rst_ext)
                          && (temp_reg > temp_set_reg);
    assign fan_span     = {FAN_FULL_TEMP[11], FAN_FULL_TEMP}
                          - {{2{temp_rst_reg[10]}}, temp_rst_reg};
    assign span_pos     = !fan_span[12] && (fan_span != 13'sd0);
    assign fan_diff     = {temp_reg[11], temp_reg} - {{2{temp_rst_reg[10]}}, temp_rst_reg};
    assign fan_num      = mul100(fan_diff[11:0]);

    assign pump_off     = hum_present_reg && (hum_reg > hum_rst_reg);
    assign pump_prop    = hum_present_reg && !(hum_reg > hum_rst_reg)
                          && (hum_reg < hum_set_reg);
    assign pump_diff    = hum_set_reg - hum_reg;
    assign pump_num     = mul100({2'b00, pump_diff});

    assign fan_div_go   = !mode_eff && control_due && fan_prop && span_pos;
    assign pump_div_go  = !mode_eff && control_due && pump_prop;

    // ---- divider step ----
    assign trial    = {1'b0, rem_reg, dvd_q_reg[DVD_W-1]} - {2'b00, dvs_reg};
    assign fits     = !trial[DVS_W+1];
    assign div_last = (cnt_reg == CNT_W'(DVD_W - 1));

    always_comb
    begin
        div_load = 1'b0;
        div_dvd  = pump_num;
        div_dvs  = {{(DVS_W-10){1'b0}}, hum_set_reg};
        if (ctl.eval_en && fan_div_go)
        begin
            div_load = 1'b1;
            div_dvd  = fan_num;
            div_dvs  = fan_span[DVS_W-1:0];
        end
        else if ((ctl.eval_en && pump_div_go) || (ctl.fan_wb && pump_pend_reg))
        begin
            div_load = 1'b1;
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = ST_EVAL;
            ST_EVAL:
                if (fan_div_go)
                    state_next = ST_FAN_DIV;
                else if (pump_div_go)
                    state_next = ST_PUMP_DIV;
                else
                    state_next = ST_DONE;
            ST_FAN_DIV:
                if (div_last)
                    state_next = ST_FAN_WB;
            ST_FAN_WB:
                state_next = pump_pend_reg ? ST_PUMP_DIV : ST_DONE;
            ST_PUMP_DIV:
                if (div_last)
                    state_next = ST_PUMP_WB;
            ST_PUMP_WB:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.eval_en  = (state_reg == ST_EVAL);
        ctl.div_step = (state_reg == ST_FAN_DIV) || (state_reg == ST_PUMP_DIV);
        ctl.fan_wb   = (state_reg == ST_FAN_WB);
        ctl.pump_wb  = (state_reg == ST_PUMP_WB);
        ctl.out_load = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---- settings ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_period_reg  <= 16'd1000;
            control_period_reg <= 16'd1000;
            setting_tmo_reg    <= 32'd30000;
            temp_set_reg       <= 12'sd280;
            temp_rst_reg       <= 11'sd250;
            hum_set_reg        <= 10'd400;
            hum_rst_reg        <= 10'd600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SENSOR_PERIOD:  sensor_period_reg  <= cfg_data[15:0];
                REG_CONTROL_PERIOD: control_period_reg <= cfg_data[15:0];
                REG_SETTING_TMO:    setting_tmo_reg    <= cfg_data[31:0];
                REG_TEMP_SET:       temp_set_reg       <= cfg_data[11:0];
                REG_TEMP_RST:       temp_rst_reg       <= cfg_data[10:0];
                REG_HUM_SET:        hum_set_reg        <= cfg_data[9:0];
                REG_HUM_RST:        hum_rst_reg        <= cfg_data[9:0];
                default:            ;
            endcase
        end
    end

    // ---- poll capture ----
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            now_reg          <= s_axis_tdata[31:0];
            temp_reg         <= s_axis_tdata[43:32];
            temp_present_reg <= s_axis_tdata[44];
            hum_reg          <= s_axis_tdata[54:45];
            hum_present_reg  <= s_axis_tdata[55];
            ui_reg           <= s_axis_tdata[87:56];
            enter_reg        <= s_axis_tdata[88];
        end
    end

    // ---- controller state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            last_sensor_reg  <= 32'd0;
            last_control_reg <= 32'd0;
            fan_on_reg       <= 1'b0;
            fan_duty_reg     <= 7'd0;
            pump_on_reg      <= 1'b0;
            pump_duty_reg    <= 7'd0;
            sensor_pulse_reg <= 1'b0;
            forced_reg       <= 1'b0;
            to_main_reg      <= 1'b0;
            pump_pend_reg    <= 1'b0;
        end
        else if (ctl.eval_en)
        begin
            sensor_pulse_reg <= 1'b0;
            forced_reg       <= mode_eff;
            to_main_reg      <= mode_eff && tmo_hit;
            pump_pend_reg    <= pump_div_go;
            mode_reg         <= mode_eff && !tmo_hit;
            if (mode_eff)
            begin
                fan_on_reg  <= 1'b1;
                pump_on_reg <= 1'b1;
            end
            else
            begin
                if (sensor_due)
                begin
                    last_sensor_reg  <= now_reg;
                    sensor_pulse_reg <= 1'b1;
                end
                if (control_due)
                begin
                    last_control_reg <= now_reg;
                    if (fan_off)
                    begin
                        fan_on_reg   <= 1'b0;
                        fan_duty_reg <= 7'd0;
                    end
                    else if (fan_prop && !span_pos)
                    begin
                        fan_on_reg   <= 1'b1;
                        fan_duty_reg <= DUTY_MAX;
                    end
                    if (pump_off)
                    begin
                        pump_on_reg   <= 1'b0;
                        pump_duty_reg <= 7'd0;
                    end
                end
            end
        end
        else if (ctl.fan_wb)
        begin
            fan_on_reg   <= 1'b1;
            fan_duty_reg <= (dvd_q_reg > DVD_W'(DUTY_MAX)) ? DUTY_MAX : dvd_q_reg[6:0];
        end
        else if (ctl.pump_wb)
        begin
            // quotient never exceeds 100 here
            pump_on_reg   <= 1'b1;
            pump_duty_reg <= dvd_q_reg[6:0];
            pump_pend_reg <= 1'b0;
        end
    end

    // ---- shared restoring divider ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (div_load)
            cnt_reg <= '0;
        else if (ctl.div_step)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            dvd_q_reg <= div_dvd;
            dvs_reg   <= div_dvs;
            rem_reg   <= '0;
        end
        else if (ctl.div_step)
        begin
            dvd_q_reg <= {dvd_q_reg[DVD_W-2:0], fits};
            rem_reg   <= fits ? trial[DVS_W-1:0] : {rem_reg[DVS_W-2:0], dvd_q_reg[DVD_W-1]};
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
            out_data_reg <= {4'd0, to_main_reg, forced_reg, sensor_pulse_reg,
                             pump_duty_reg, pump_on_reg, fan_duty_reg, fan_on_reg,
                             mode_reg};
    end

    // ---- checks ----
    `HFPC_ASSERT_NXT(a_accept_eval, s_axis_tvalid && s_axis_tready, state_reg == ST_EVAL, "accepted poll not evaluated")
    `HFPC_ASSERT_IMP(a_cnt_range, ctl.div_step, cnt_reg < CNT_W'(DVD_W), "divider count overran")
    `HFPC_ASSERT_IMP(a_duty_max, 1'b1, fan_duty_reg <= DUTY_MAX && pump_duty_reg <= DUTY_MAX, "duty above 100")
    `HFPC_ASSERT_IMP(a_forced_on, m_axis_tvalid && m_axis_tdata[18], m_axis_tdata[1] && m_axis_tdata[9], "forced beat without enables")
    `HFPC_ASSERT_IMP(a_to_main, m_axis_tvalid && m_axis_tdata[19], !m_axis_tdata[0] && !m_axis_tdata[17], "timeout beat in wrong mode")

endmodule
